// ===== rtl/mmwbr_pkg.sv =====
`default_nettype none

package mmwbr_pkg;

   // payload widths fixed by the item formats
   localparam int SAMPLE_WIDTH       = 16;
   localparam int GAIN_WIDTH         = 16;
   localparam int ROW_COUNT_WIDTH    = 5;
   localparam int ROW_INDEX_WIDTH    = 4;
   localparam int COLUMN_INDEX_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = 16;

   // shared multiplier operand and product widths
   localparam int MUL_WIDTH  = 18;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;

   // reset values of the configuration registers
   localparam logic [ROW_COUNT_WIDTH-1:0] ROW_COUNT_RESET = 5'd4;
   localparam logic [GAIN_WIDTH-1:0]      GAIN_RESET      = 16'd256;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN      = 1'b1;

   // fixed point one in q.15 and rounding half for the dot row
   localparam int FULL_SCALE = 32768;

   // utf-8 encoding of a braille cell
   localparam logic [7:0] SPACE_BYTE   = 8'h20;
   localparam logic [7:0] UTF8_LEAD    = 8'hE2;
   localparam logic [7:0] UTF8_MID     = 8'hA0;
   localparam logic [7:0] UTF8_CONT    = 8'h80;
   localparam logic [7:0] LOW_SIX_MASK = 8'h3F;
   localparam logic [1:0] COUNT_SPACE  = 2'd1;
   localparam logic [1:0] COUNT_BRAILLE = 2'd3;

   // braille dot bits, left column then right column, dot rows 0..3 of a cell
   localparam logic [7:0] DOT_BITS [2][4] = '{
      '{8'h01, 8'h02, 8'h04, 8'h40},
      '{8'h08, 8'h10, 8'h20, 8'h80}
   };

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_max;
      logic signed [SAMPLE_WIDTH-1:0] left_min;
      logic signed [SAMPLE_WIDTH-1:0] right_max;
      logic signed [SAMPLE_WIDTH-1:0] right_min;
      logic                           frame_start;
   } req_item_type;

   typedef struct packed {
      logic [ROW_INDEX_WIDTH-1:0]    row_index;
      logic [COLUMN_INDEX_WIDTH-1:0] column_index;
      logic [7:0]                    glyph_byte0;
      logic [7:0]                    glyph_byte1;
      logic [7:0]                    glyph_byte2;
      logic [1:0]                    byte_count;
      logic                          last_of_column;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] byte_count;
   } glyph_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DOT,
      ST_STORE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/mmwbr_mul.sv =====
`default_nettype none

module mmwbr_mul
   import mmwbr_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic signed [MUL_WIDTH-1:0]  op_a,
   input  wire logic signed [MUL_WIDTH-1:0]  op_b,
   output logic signed [PROD_WIDTH-1:0]      product
);

   logic signed [PROD_WIDTH-1:0] product_ff;
   logic signed [PROD_WIDTH-1:0] product_in;

   // signed multiply, result registered
   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== rtl/mmwbr_glyph.sv =====
`default_nettype none

module mmwbr_glyph
   import mmwbr_pkg::*;
#(
   parameter  int MAX_ROWS = 16,
   localparam int RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int DotW     = $clog2(4 * MAX_ROWS)
)
(
   input  wire logic [RowW-1:0]          char_row,
   input  wire logic [3:0][DotW-1:0]     span_rows,
   output glyph_type                     glyph
);

   logic [DotW-1:0]   left_top;
   logic [DotW-1:0]   left_bot;
   logic [DotW-1:0]   right_top;
   logic [DotW-1:0]   right_bot;
   logic [RowW+1:0]   dot_row;
   logic [7:0]        mask;

   // order each span so that top is never below bottom
   always_comb begin
      if (span_rows[0] > span_rows[1]) begin
         left_top = span_rows[1];
         left_bot = span_rows[0];
      end else begin
         left_top = span_rows[0];
         left_bot = span_rows[1];
      end
      if (span_rows[2] > span_rows[3]) begin
         right_top = span_rows[3];
         right_bot = span_rows[2];
      end else begin
         right_top = span_rows[2];
         right_bot = span_rows[3];
      end
   end

   // set the dots of this cell that fall inside each span
   always_comb begin
      mask    = '0;
      dot_row = '0;
      for (int k = 0; k < 4; k++) begin
         dot_row = {char_row, 2'(k)};
         if (dot_row >= (RowW+2)'(left_top) && dot_row <= (RowW+2)'(left_bot)) begin
            mask = mask | DOT_BITS[0][k];
         end
         if (dot_row >= (RowW+2)'(right_top) && dot_row <= (RowW+2)'(right_bot)) begin
            mask = mask | DOT_BITS[1][k];
         end
      end
   end

   // utf-8 bytes of the cell, a space when no dot is set
   always_comb begin
      if (mask == '0) begin
         glyph.byte0      = SPACE_BYTE;
         glyph.byte1      = '0;
         glyph.byte2      = '0;
         glyph.byte_count = COUNT_SPACE;
      end else begin
         glyph.byte0      = UTF8_LEAD;
         glyph.byte1      = UTF8_MID | {6'b0, mask[7:6]};
         glyph.byte2      = UTF8_CONT | (mask & LOW_SIX_MASK);
         glyph.byte_count = COUNT_BRAILLE;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/minmax_waveform_braille_raster_unit.sv =====
// Braille waveform column rasterizer.
// req channel: one item per character column (left and right min/max peak
// bins in Q1.15, plus frame_start). rsp channel: one glyph item per character
// row, top row first, tagged with row and column, last_of_column on the bottom.
// csr channel: index 0 row_count, index 1 gain (Q8.8); always ready, to be
// written only while no item is in flight.
// Sequence: an item is taken while idle, then each of the four bins goes
// through the single shared 18x18 multiplier twice (gain scaling, then the
// dot row product) plus a store step. Glyphs then leave one per cycle while
// rsp is not stalled, and no new item is taken until the column is done.
// row_count 0 takes the item and emits nothing. Stall on rsp holds the
// output register and the glyph sequencer;
// req_stall stays high until the last glyph of the column is loaded.
// Reset (synchronous, active high) returns row_count to 4, gain to 1.0,
// the column counter to zero and empties the output register.
`default_nettype none

module minmax_waveform_braille_raster_unit
   import mmwbr_pkg::*;
#(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 1024
)
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire req_item_type                  req_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rsp_item_type                       rsp_item,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DotW = $clog2(4 * MAX_ROWS);
   localparam int ColW = $clog2(MAX_COLUMNS);
   localparam int RW   = PROD_WIDTH - 16;

   state_type                     state_ff, state_in;
   req_item_type                  item_ff, item_in;
   logic [1:0]                    bin_ff, bin_in;
   logic [RowW-1:0]               row_ff, row_in;
   logic [RowW-1:0]               last_row_ff, last_row_in;
   logic [ColW-1:0]               col_ff, col_in;
   logic [ColW-1:0]               counter_ff, counter_in;
   logic [ROW_COUNT_WIDTH-1:0]    row_count_ff, row_count_in;
   logic [GAIN_WIDTH-1:0]         gain_ff, gain_in;
   logic [3:0][DotW-1:0]          dot_row_ff, dot_row_in;
   rsp_item_type                  out_ff, out_in;
   logic                          out_valid_ff, out_valid_in;

   logic                          accept;
   logic                          mul_load;
   logic signed [MUL_WIDTH-1:0]   op_a;
   logic signed [MUL_WIDTH-1:0]   op_b;
   logic signed [PROD_WIDTH-1:0]  product;
   logic signed [SAMPLE_WIDTH-1:0] bin_value;
   logic signed [PROD_WIDTH-9:0]  scaled;
   logic signed [MUL_WIDTH-1:0]   clamped;
   logic signed [MUL_WIDTH-1:0]   span_from_top;
   logic [DotW-1:0]               dot_max;
   logic signed [PROD_WIDTH-1:0]  rounded;
   logic [RW-1:0]                 dot_wide;
   logic [DotW-1:0]               dot_new;
   logic [ROW_COUNT_WIDTH-1:0]    rows_eff;
   logic [ColW-1:0]               col_accept;
   logic                          emit_load;
   logic                          last_row;
   glyph_type                     glyph;

   // shared multiplier
   mmwbr_mul u_mul (
      .clock   (clock),
      .load    (mul_load),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // glyph encoder for the row being emitted
   mmwbr_glyph #(
      .MAX_ROWS (MAX_ROWS)
   ) u_glyph (
      .char_row  (row_ff),
      .span_rows (dot_row_ff),
      .glyph     (glyph)
   );

   // bin selected for the current pass
   always_comb begin
      case (bin_ff)
         2'd0:    bin_value = item_ff.left_max;
         2'd1:    bin_value = item_ff.left_min;
         2'd2:    bin_value = item_ff.right_max;
         default: bin_value = item_ff.right_min;
      endcase
   end

   // gain product floored to q.15 and clamped to [-1, +1]
   assign scaled = $signed(product[PROD_WIDTH-1:8]);
   always_comb begin
      if (scaled > (PROD_WIDTH-8)'(FULL_SCALE)) begin
         clamped = MUL_WIDTH'(FULL_SCALE);
      end else if (scaled < -(PROD_WIDTH-8)'(FULL_SCALE)) begin
         clamped = -MUL_WIDTH'(FULL_SCALE);
      end else begin
         clamped = MUL_WIDTH'(scaled);
      end
   end
   assign span_from_top = MUL_WIDTH'(FULL_SCALE) - clamped;

   // dot row count minus one, and the rounded dot row from the product
   assign dot_max  = DotW'({last_row_ff, 2'b11});
   assign rounded  = product + PROD_WIDTH'(FULL_SCALE);
   assign dot_wide = rounded[PROD_WIDTH-1:16];
   assign dot_new  = (dot_wide > RW'(dot_max)) ? dot_max : dot_wide[DotW-1:0];

   // row limit and column number of an arriving item
   assign rows_eff   = (row_count_ff > ROW_COUNT_WIDTH'(MAX_ROWS)) ?
                       ROW_COUNT_WIDTH'(MAX_ROWS) : row_count_ff;
   assign col_accept = req_item.frame_start ? '0 : counter_ff;

   assign accept    = req_valid && !req_stall;
   assign last_row  = (row_ff == last_row_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      bin_in       = bin_ff;
      row_in       = row_ff;
      last_row_in  = last_row_ff;
      col_in       = col_ff;
      counter_in   = counter_ff;
      dot_row_in   = dot_row_ff;
      mul_load     = 1'b0;
      op_a         = '0;
      op_b         = '0;
      emit_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && rows_eff != '0) begin
               item_in     = req_item;
               bin_in      = '0;
               last_row_in = RowW'(rows_eff - ROW_COUNT_WIDTH'(1));
               col_in      = col_accept;
               counter_in  = (col_accept == ColW'(MAX_COLUMNS - 1)) ?
                             '0 : col_accept + ColW'(1);
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mul_load = 1'b1;
            op_a     = MUL_WIDTH'(bin_value);
            op_b     = $signed({2'b00, gain_ff});
            state_in = ST_DOT;
         end
         ST_DOT: begin
            mul_load = 1'b1;
            op_a     = span_from_top;
            op_b     = $signed(MUL_WIDTH'(dot_max));
            state_in = ST_STORE;
         end
         ST_STORE: begin
            dot_row_in[bin_ff] = dot_new;
            bin_in             = bin_ff + 2'd1;
            if (bin_ff == 2'd3) begin
               row_in   = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || !rsp_stall) begin
               emit_load = 1'b1;
               row_in    = row_ff + RowW'(1);
               if (last_row) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_in = out_ff;
      if (emit_load) begin
         out_in.row_index      = ROW_INDEX_WIDTH'(row_ff);
         out_in.column_index   = COLUMN_INDEX_WIDTH'(col_ff);
         out_in.glyph_byte0    = glyph.byte0;
         out_in.glyph_byte1    = glyph.byte1;
         out_in.glyph_byte2    = glyph.byte2;
         out_in.byte_count     = glyph.byte_count;
         out_in.last_of_column = last_row;
      end
      if (emit_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      row_count_in = row_count_ff;
      gain_in      = gain_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata[ROW_COUNT_WIDTH-1:0];
            CSR_GAIN:      gain_in      = csr_wdata[GAIN_WIDTH-1:0];
            default:       row_count_in = row_count_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         row_count_ff <= ROW_COUNT_RESET;
         gain_ff      <= GAIN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         row_count_ff <= row_count_in;
         gain_ff      <= gain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      bin_ff      <= bin_in;
      row_ff      <= row_in;
      last_row_ff <= last_row_in;
      col_ff      <= col_in;
      dot_row_ff  <= dot_row_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

`ifndef NO_ASSERTIONS
   // an item with rows to draw starts the scaling pass
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept && rows_eff != '0 |=> state_ff == ST_SCALE)
      else $error("accepted item did not start the sequencer");

   // emitted row never passes the last row of the column
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> row_ff <= last_row_ff)
      else $error("glyph row beyond last row");

   // byte count agrees with the lead byte
   a_glyph_form: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         (out_ff.byte_count == COUNT_SPACE && out_ff.glyph_byte0 == SPACE_BYTE) ||
         (out_ff.byte_count == COUNT_BRAILLE && out_ff.glyph_byte0 == UTF8_LEAD))
      else $error("glyph bytes inconsistent with byte count");

   // column counter stays within the column limit
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      ColW'(MAX_COLUMNS - 1) >= counter_ff)
      else $error("column counter out of range");
`endif

endmodule

`default_nettype wire
